FILE: hw/rtl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants, codes and types of the instruction executor.
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int DATA_WORDS = 1024;
	localparam int DMEM_AW    = $clog2(DATA_WORDS);

	localparam logic [31:0] SP_RESET    = 32'h0100_0000;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
	localparam logic [31:0] HALT_PC     = 32'hFFFF_FFFF;
	localparam logic [31:0] TARGET_MASK = 32'h03FF_FFFF;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_SLTIU   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_COP0    = 6'h10;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SW      = 6'h2B;

	localparam logic [5:0] FN_SLL   = 6'h00;
	localparam logic [5:0] FN_SRL   = 6'h02;
	localparam logic [5:0] FN_JR    = 6'h08;
	localparam logic [5:0] FN_MULT  = 6'h18;
	localparam logic [5:0] FN_MULTU = 6'h19;
	localparam logic [5:0] FN_DIV   = 6'h1A;
	localparam logic [5:0] FN_DIVU  = 6'h1B;
	localparam logic [5:0] FN_ADD   = 6'h20;
	localparam logic [5:0] FN_ADDU  = 6'h21;
	localparam logic [5:0] FN_SUB   = 6'h22;
	localparam logic [5:0] FN_SUBU  = 6'h23;
	localparam logic [5:0] FN_AND   = 6'h24;
	localparam logic [5:0] FN_OR    = 6'h25;
	localparam logic [5:0] FN_NOR   = 6'h27;
	localparam logic [5:0] FN_SLT   = 6'h2A;
	localparam logic [5:0] FN_SLTU  = 6'h2B;

	localparam logic [1:0] CLS_R   = 2'd0;
	localparam logic [1:0] CLS_I   = 2'd1;
	localparam logic [1:0] CLS_J   = 2'd2;
	localparam logic [1:0] CLS_NOP = 2'd3;

	localparam logic [4:0] REG_V0 = 5'd2;
	localparam logic [4:0] REG_SP = 5'd29;
	localparam logic [4:0] REG_RA = 5'd31;

	typedef struct packed {
		logic load_instr;
		logic exec;
		logic mul;
		logic div_init;
		logic div_step;
		logic div_fin;
		logic load_data;
		logic commit;
		logic clear_wr;
	} cmd_t;

	typedef struct packed {
		logic is_mul;
		logic is_div;
		logic is_lw;
		logic div_last;
		logic clear_last;
	} status_t;

	function automatic logic [31:0] rf_reset_value(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			REG_SP:  v = SP_RESET;
			REG_RA:  v = ALL_ONES;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/mips_subset_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor_core
// Executes one MIPS32-subset instruction per transfer against its own
// register file, PC and word data memory, and reports one result per item.
// ----------------------------------------------------------------------------
// After reset the block fills all DATA_WORDS words of its data memory with
// all-ones, one word a cycle, before it takes the first instruction. Each
// instruction passes through register file read, execute and retire;
// multiply and load word add a step before retire, and divide runs the
// radix-2 divider, one quotient bit per cycle. One instruction is in
// flight at a time; a finished result waits in the output register while the
// next instruction is taken, and retires once that result is transferred.
module mips_subset_instruction_executor_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        instr_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        next_pc,
	output logic               halted,
	output logic signed [31:0] return_value,
	output logic               reg_written,
	output logic [4:0]         reg_index,
	output logic [31:0]        reg_value,
	output logic               mem_written,
	output logic [31:0]        mem_address,
	output logic [1:0]         instr_class,
	output logic               branch_taken,
	output logic [31:0]        executed_count,
	output logic [31:0]        taken_branch_count
);

	mse_pkg::cmd_t    cmd;
	mse_pkg::status_t sts;

	mse_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	mse_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.instr_word(instr_word),
		.next_pc(next_pc), .halted(halted), .return_value(return_value),
		.reg_written(reg_written), .reg_index(reg_index), .reg_value(reg_value),
		.mem_written(mem_written), .mem_address(mem_address),
		.instr_class(instr_class), .branch_taken(branch_taken),
		.executed_count(executed_count), .taken_branch_count(taken_branch_count)
	);

endmodule

FILE: hw/rtl/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/mse_ctrl.sv
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer: memory clear, fetch, execute, multiply, divide, load, retire.
// ----------------------------------------------------------------------------
module mse_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  mse_pkg::status_t sts,
	output mse_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_EXEC, ST_MUL, ST_DIVI, ST_DIVS, ST_DIVF, ST_LOAD, ST_WB
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign commit    = (state_q == ST_WB) && (!out_valid_q || out_ready);

	always_comb begin
		cmd            = '0;
		cmd.load_instr = in_ready && in_valid;
		cmd.exec       = (state_q == ST_EXEC);
		cmd.mul        = (state_q == ST_MUL);
		cmd.div_init   = (state_q == ST_DIVI);
		cmd.div_step   = (state_q == ST_DIVS);
		cmd.div_fin    = (state_q == ST_DIVF);
		cmd.load_data  = (state_q == ST_LOAD);
		cmd.commit     = commit;
		cmd.clear_wr   = (state_q == ST_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: if (sts.clear_last) state_q <= ST_IDLE;
				ST_IDLE:  if (in_valid) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (sts.is_mul)
						state_q <= ST_MUL;
					else if (sts.is_div)
						state_q <= ST_DIVI;
					else if (sts.is_lw)
						state_q <= ST_LOAD;
					else
						state_q <= ST_WB;
				end
				ST_MUL:   state_q <= ST_WB;
				ST_DIVI:  state_q <= ST_DIVS;
				ST_DIVS:  if (sts.div_last) state_q <= ST_DIVF;
				ST_DIVF:  state_q <= ST_WB;
				ST_LOAD:  state_q <= ST_WB;
				ST_WB:    if (commit) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/mse_dp.sv
// ----------------------------------------------------------------------------
// mse_dp
// Datapath: register file, data memory, ALU, multiplier, radix-2 divider,
// architectural state and result registers.
// ----------------------------------------------------------------------------
module mse_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mse_pkg::cmd_t       cmd,
	output mse_pkg::status_t    sts,
	input  logic [31:0]         instr_word,
	output logic [31:0]         next_pc,
	output logic                halted,
	output logic signed [31:0]  return_value,
	output logic                reg_written,
	output logic [4:0]          reg_index,
	output logic [31:0]         reg_value,
	output logic                mem_written,
	output logic [31:0]         mem_address,
	output logic [1:0]          instr_class,
	output logic                branch_taken,
	output logic [31:0]         executed_count,
	output logic [31:0]         taken_branch_count
);

	localparam int AW = mse_pkg::DMEM_AW;

	logic [31:0] instr_q;
	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sh;
	logic [15:0] imm;
	logic [31:0] sx, zx;

	assign op  = instr_q[31:26];
	assign rs  = instr_q[25:21];
	assign rt  = instr_q[20:16];
	assign rd  = instr_q[15:11];
	assign sh  = instr_q[10:6];
	assign fn  = instr_q[5:0];
	assign imm = instr_q[15:0];
	assign sx  = {{16{imm[15]}}, imm};
	assign zx  = {16'd0, imm};

	logic [31:0] pc_q, pc4;
	logic [31:0] a_q, b_q;
	logic        wr_q, mw_q, taken_q;
	logic [4:0]  widx_q;
	logic [31:0] wval_q, npc_q, maddr_q;
	logic [1:0]  cls_q;

	logic [31:0] rf_vld_q;
	logic        va_q, vb_q;
	logic [31:0] rf_rdata_a, rf_rdata_b, a, b;
	logic        rf_we;

	assign rf_we = cmd.commit && wr_q;

	mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(widx_q), .wdata(wval_q),
		.re(cmd.load_instr), .raddr(instr_word[25:21]), .rdata(rf_rdata_a)
	);

	mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(widx_q), .wdata(wval_q),
		.re(cmd.load_instr), .raddr(instr_word[20:16]), .rdata(rf_rdata_b)
	);

	assign a = va_q ? rf_rdata_a : mse_pkg::rf_reset_value(rs);
	assign b = vb_q ? rf_rdata_b : mse_pkg::rf_reset_value(rt);

	logic [AW-1:0] clr_addr_q;
	logic          dm_we;
	logic [AW-1:0] dm_waddr, dm_raddr;
	logic [31:0]   dm_wdata, dm_rdata;
	logic [31:0]   ea;

	assign ea       = a + sx;
	assign dm_raddr = ea[AW+1:2];
	assign dm_we    = cmd.clear_wr || (cmd.commit && mw_q);
	assign dm_waddr = cmd.clear_wr ? clr_addr_q : maddr_q[AW+1:2];
	assign dm_wdata = cmd.clear_wr ? mse_pkg::ALL_ONES : b_q;

	mse_ram #(.WIDTH(32), .DEPTH(mse_pkg::DATA_WORDS)) u_dmem (
		.clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
		.re(cmd.exec), .raddr(dm_raddr), .rdata(dm_rdata)
	);

	logic        wr_d, mw_d, taken_d;
	logic [4:0]  widx_d;
	logic [31:0] wval_d, npc_d, maddr_d;
	logic [1:0]  cls_d;

	assign pc4 = pc_q + 32'd4;

	always_comb begin
		wr_d    = 1'b0;
		mw_d    = 1'b0;
		taken_d = 1'b0;
		widx_d  = '0;
		wval_d  = '0;
		maddr_d = '0;
		npc_d   = pc4;
		cls_d   = mse_pkg::CLS_I;
		if (instr_q == '0) begin
			cls_d = mse_pkg::CLS_NOP;
		end else if (op == mse_pkg::OP_SPECIAL || op == mse_pkg::OP_COP0) begin
			cls_d = mse_pkg::CLS_R;
			if (op == mse_pkg::OP_SPECIAL) begin
				wr_d   = 1'b1;
				widx_d = rd;
				case (fn)
					mse_pkg::FN_ADD, mse_pkg::FN_ADDU: wval_d = a + b;
					mse_pkg::FN_SUB, mse_pkg::FN_SUBU: wval_d = a - b;
					mse_pkg::FN_AND:   wval_d = a & b;
					mse_pkg::FN_OR:    wval_d = a | b;
					mse_pkg::FN_NOR:   wval_d = ~(a | b);
					mse_pkg::FN_SLT:   wval_d = {31'd0, $signed(a) < $signed(b)};
					mse_pkg::FN_SLTU:  wval_d = {31'd0, a < b};
					mse_pkg::FN_SLL:   wval_d = b << sh;
					mse_pkg::FN_SRL:   wval_d = b >> sh;
					mse_pkg::FN_MULT, mse_pkg::FN_MULTU,
					mse_pkg::FN_DIV, mse_pkg::FN_DIVU: wval_d = '0;
					mse_pkg::FN_JR: begin
						wr_d  = 1'b0;
						npc_d = a;
					end
					default: wr_d = 1'b0;
				endcase
			end
		end else if (op == mse_pkg::OP_J || op == mse_pkg::OP_JAL) begin
			cls_d = mse_pkg::CLS_J;
			npc_d = {pc4[31:28], instr_q[25:0], 2'b00};
			if (op == mse_pkg::OP_JAL) begin
				wr_d   = 1'b1;
				widx_d = mse_pkg::REG_RA;
				wval_d = pc_q + 32'd8;
			end
		end else begin
			widx_d = rt;
			case (op)
				mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin
					wr_d = 1'b1; wval_d = a + sx;
				end
				mse_pkg::OP_ANDI: begin
					wr_d = 1'b1; wval_d = a & zx;
				end
				mse_pkg::OP_ORI: begin
					wr_d = 1'b1; wval_d = a | zx;
				end
				mse_pkg::OP_SLTI: begin
					wr_d = 1'b1; wval_d = {31'd0, $signed(a) < $signed(sx)};
				end
				mse_pkg::OP_SLTIU: begin
					wr_d = 1'b1; wval_d = {31'd0, a < sx};
				end
				mse_pkg::OP_BEQ: taken_d = (a == b);
				mse_pkg::OP_BNE: taken_d = (a != b);
				mse_pkg::OP_LW: begin
					wr_d = 1'b1; maddr_d = ea;
				end
				mse_pkg::OP_SW: begin
					mw_d = 1'b1; maddr_d = ea;
				end
				default: wr_d = 1'b0;
			endcase
			if (taken_d)
				npc_d = pc4 + {sx[29:0], 2'b00};
		end
		if (widx_d == '0)
			wr_d = 1'b0;
		if (!wr_d)
			widx_d = '0;
	end

	logic [31:0] rem_q, quo_q, den_q;
	logic [4:0]  cnt_q;
	logic        neg_q, dzero_q;
	logic [32:0] trial;
	logic        sgn;

	assign sgn   = (fn == mse_pkg::FN_DIV);
	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

	always_comb begin
		sts            = '0;
		sts.is_mul     = (instr_q[31:26] == mse_pkg::OP_SPECIAL)
			&& (fn == mse_pkg::FN_MULT || fn == mse_pkg::FN_MULTU);
		sts.is_div     = (instr_q[31:26] == mse_pkg::OP_SPECIAL)
			&& (fn == mse_pkg::FN_DIV || fn == mse_pkg::FN_DIVU);
		sts.is_lw      = (op == mse_pkg::OP_LW);
		sts.div_last   = (cnt_q == 5'd31);
		sts.clear_last = (clr_addr_q == AW'(mse_pkg::DATA_WORDS - 1));
	end

	logic [31:0] pc_r_q, v0_q, exec_cnt_q, taken_cnt_q;
	logic        halt_q, rwr_q, rmw_q, rtaken_q;
	logic [4:0]  ridx_q;
	logic [31:0] rval_q, raddr_q;
	logic [1:0]  rcls_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q    <= '0;
			pc_q        <= '0;
			v0_q        <= '0;
			exec_cnt_q  <= '0;
			taken_cnt_q <= '0;
			clr_addr_q  <= '0;
		end else begin
			if (cmd.clear_wr)
				clr_addr_q <= clr_addr_q + AW'(1);
			if (cmd.commit) begin
				pc_q        <= npc_q;
				exec_cnt_q  <= exec_cnt_q + 32'd1;
				taken_cnt_q <= taken_cnt_q + {31'd0, taken_q};
				if (wr_q) begin
					rf_vld_q[widx_q] <= 1'b1;
					if (widx_q == mse_pkg::REG_V0)
						v0_q <= wval_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_instr) begin
			instr_q <= instr_word;
			va_q    <= rf_vld_q[instr_word[25:21]];
			vb_q    <= rf_vld_q[instr_word[20:16]];
		end
		if (cmd.exec) begin
			a_q     <= a;
			b_q     <= b;
			wr_q    <= wr_d;
			widx_q  <= widx_d;
			wval_q  <= wval_d;
			mw_q    <= mw_d;
			maddr_q <= maddr_d;
			npc_q   <= npc_d;
			cls_q   <= cls_d;
			taken_q <= taken_d;
		end
		if (cmd.mul)
			wval_q <= a_q * b_q;
		if (cmd.div_init) begin
			rem_q   <= '0;
			quo_q   <= (sgn && a_q[31]) ? -a_q : a_q;
			den_q   <= (sgn && b_q[31]) ? -b_q : b_q;
			neg_q   <= sgn && (a_q[31] ^ b_q[31]);
			dzero_q <= (b_q == '0);
			cnt_q   <= '0;
		end
		if (cmd.div_step) begin
			cnt_q <= cnt_q + 5'd1;
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (cmd.div_fin)
			wval_q <= dzero_q ? mse_pkg::ALL_ONES : (neg_q ? -quo_q : quo_q);
		if (cmd.load_data)
			wval_q <= dm_rdata;
		if (cmd.commit) begin
			pc_r_q   <= npc_q;
			halt_q   <= (npc_q == mse_pkg::HALT_PC);
			rwr_q    <= wr_q;
			ridx_q   <= widx_q;
			rval_q   <= wr_q ? wval_q : '0;
			rmw_q    <= mw_q;
			raddr_q  <= maddr_q;
			rcls_q   <= cls_q;
			rtaken_q <= taken_q;
		end
	end

	assign next_pc            = pc_r_q;
	assign halted             = halt_q;
	assign return_value       = v0_q;
	assign reg_written        = rwr_q;
	assign reg_index          = ridx_q;
	assign reg_value          = rval_q;
	assign mem_written        = rmw_q;
	assign mem_address        = raddr_q;
	assign instr_class        = rcls_q;
	assign branch_taken       = rtaken_q;
	assign executed_count     = exec_cnt_q;
	assign taken_branch_count = taken_cnt_q;

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIPS32-subset executor. A directed table of
// instructions covers the special cases, then constrained-by-hand random
// programs run against a behavioral model of the register file, PC and data
// memory. Both handshake sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] npc;
		logic        hlt;
		logic [31:0] v0;
		logic        rwr;
		logic [4:0]  ridx;
		logic [31:0] rval;
		logic        mwr;
		logic [31:0] maddr;
		logic [1:0]  cls;
		logic        tkn;
		logic [31:0] nexec;
		logic [31:0] ntaken;
	} retire_t;

	typedef struct {
		logic [31:0] word;
		logic        known;
		retire_t     res;
	} row_t;

	typedef struct {
		retire_t want;
		logic    known;
		retire_t typed;
	} check_t;

	localparam int N_RANDOM  = 2000;
	localparam int CYCLE_CAP = 2000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] instr_word;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] next_pc;
	logic        halted;
	logic signed [31:0] return_value;
	logic        reg_written;
	logic [4:0]  reg_index;
	logic [31:0] reg_value;
	logic        mem_written;
	logic [31:0] mem_address;
	logic [1:0]  instr_class;
	logic        branch_taken;
	logic [31:0] executed_count;
	logic [31:0] taken_branch_count;

	mips_subset_instruction_executor_core uut (.*);

	logic [31:0] gpr [32];
	logic [31:0] pc;
	logic [31:0] dmem [mse_pkg::DATA_WORDS];
	logic [31:0] exec_total;
	logic [31:0] taken_total;

	check_t  pending_q [$];
	int      errors = 0;
	int      sent = 0;
	int      retired = 0;
	int      cycles = 0;
	int      send_idle_pct;
	int      recv_stall_pct;
	row_t    table_rows [$];
	logic    drv_known;
	retire_t drv_typed;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
			logic [4:0] sh, logic [5:0] fn);
		return {mse_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] quot_signed(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma, mb, q;
		if (b == '0)
			return mse_pkg::ALL_ONES;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	task automatic model_reset();
		for (int i = 0; i < 32; i++)
			gpr[i] = '0;
		gpr[mse_pkg::REG_SP] = mse_pkg::SP_RESET;
		gpr[mse_pkg::REG_RA] = mse_pkg::ALL_ONES;
		pc = '0;
		for (int i = 0; i < mse_pkg::DATA_WORDS; i++)
			dmem[i] = mse_pkg::ALL_ONES;
		exec_total = '0;
		taken_total = '0;
	endtask

	task automatic execute_instr(input logic [31:0] w, output retire_t r);
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd, sh, widx;
		logic [31:0] a, b, sx, imm, pc4, npc, wval, maddr;
		logic [1:0]  cls;
		logic        wr, mw, tkn;
		op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
		sh = w[10:6]; fn = w[5:0];
		imm = {16'h0, w[15:0]};
		sx = {{16{w[15]}}, w[15:0]};
		a = gpr[rs]; b = gpr[rt];
		pc4 = pc + 32'd4;
		npc = pc4;
		wr = 1'b0; mw = 1'b0; tkn = 1'b0; widx = '0; wval = '0; maddr = '0;
		if (w == '0) begin
			cls = mse_pkg::CLS_NOP;
		end else if (op == mse_pkg::OP_SPECIAL || op == mse_pkg::OP_COP0) begin
			cls = mse_pkg::CLS_R;
			if (op == mse_pkg::OP_SPECIAL) begin
				wr = 1'b1;
				widx = rd;
				case (fn)
					mse_pkg::FN_ADD, mse_pkg::FN_ADDU: wval = a + b;
					mse_pkg::FN_SUB, mse_pkg::FN_SUBU: wval = a - b;
					mse_pkg::FN_AND: wval = a & b;
					mse_pkg::FN_OR: wval = a | b;
					mse_pkg::FN_NOR: wval = ~(a | b);
					mse_pkg::FN_SLT: wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
					mse_pkg::FN_SLTU: wval = (a < b) ? 32'd1 : 32'd0;
					mse_pkg::FN_SLL: wval = b << sh;
					mse_pkg::FN_SRL: wval = b >> sh;
					mse_pkg::FN_MULT, mse_pkg::FN_MULTU: wval = a * b;
					mse_pkg::FN_DIV: wval = quot_signed(a, b);
					mse_pkg::FN_DIVU: wval = (b == '0) ? mse_pkg::ALL_ONES : a / b;
					mse_pkg::FN_JR: begin
						wr = 1'b0;
						npc = a;
					end
					default: wr = 1'b0;
				endcase
			end
		end else if (op == mse_pkg::OP_J || op == mse_pkg::OP_JAL) begin
			cls = mse_pkg::CLS_J;
			npc = {pc4[31:28], w[25:0], 2'b00};
			if (op == mse_pkg::OP_JAL) begin
				wr = 1'b1;
				widx = mse_pkg::REG_RA;
				wval = pc + 32'd8;
			end
		end else begin
			cls = mse_pkg::CLS_I;
			widx = rt;
			case (op)
				mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin wr = 1'b1; wval = a + sx; end
				mse_pkg::OP_ANDI: begin wr = 1'b1; wval = a & imm; end
				mse_pkg::OP_ORI: begin wr = 1'b1; wval = a | imm; end
				mse_pkg::OP_SLTI: begin
					wr = 1'b1; wval = ($signed(a) < $signed(sx)) ? 32'd1 : 32'd0;
				end
				mse_pkg::OP_SLTIU: begin wr = 1'b1; wval = (a < sx) ? 32'd1 : 32'd0; end
				mse_pkg::OP_BEQ: tkn = (a == b);
				mse_pkg::OP_BNE: tkn = (a != b);
				mse_pkg::OP_LW: begin
					maddr = a + sx;
					wr = 1'b1;
					wval = dmem[(maddr >> 2) % mse_pkg::DATA_WORDS];
				end
				mse_pkg::OP_SW: begin
					maddr = a + sx;
					mw = 1'b1;
					dmem[(maddr >> 2) % mse_pkg::DATA_WORDS] = b;
				end
				default: ;
			endcase
			if (tkn) begin
				npc = pc4 + (sx << 2);
				taken_total = taken_total + 32'd1;
			end
		end
		if (wr && widx != '0) begin
			gpr[widx] = wval;
		end else begin
			wr = 1'b0; widx = '0; wval = '0;
		end
		pc = npc;
		exec_total = exec_total + 32'd1;
		r = '{npc: npc, hlt: (npc == mse_pkg::HALT_PC), v0: gpr[mse_pkg::REG_V0],
			rwr: wr, ridx: widx, rval: wval, mwr: mw, maddr: maddr, cls: cls, tkn: tkn,
			nexec: exec_total, ntaken: taken_total};
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("tb_top: result %0d %s got %h want %h", retired, field, got, want);
		errors++;
	endtask

	task automatic compare_result(input retire_t want);
		if (next_pc !== want.npc) report_mismatch("next_pc", next_pc, want.npc);
		if (halted !== want.hlt)
			report_mismatch("halted", 32'(halted), 32'(want.hlt));
		if (return_value !== want.v0)
			report_mismatch("return_value", return_value, want.v0);
		if (reg_written !== want.rwr)
			report_mismatch("reg_written", 32'(reg_written), 32'(want.rwr));
		if (reg_index !== want.ridx)
			report_mismatch("reg_index", 32'(reg_index), 32'(want.ridx));
		if (reg_value !== want.rval) report_mismatch("reg_value", reg_value, want.rval);
		if (mem_written !== want.mwr)
			report_mismatch("mem_written", 32'(mem_written), 32'(want.mwr));
		if (mem_address !== want.maddr)
			report_mismatch("mem_address", mem_address, want.maddr);
		if (instr_class !== want.cls)
			report_mismatch("instr_class", 32'(instr_class), 32'(want.cls));
		if (branch_taken !== want.tkn)
			report_mismatch("branch_taken", 32'(branch_taken), 32'(want.tkn));
		if (executed_count !== want.nexec)
			report_mismatch("executed_count", executed_count, want.nexec);
		if (taken_branch_count !== want.ntaken)
			report_mismatch("taken_branch_count", taken_branch_count, want.ntaken);
	endtask

	function automatic logic [31:0] random_word();
		logic [4:0]  rs, rt, rd;
		logic [15:0] imm;
		int          pick;
		logic [5:0]  fns [16] = '{mse_pkg::FN_ADD, mse_pkg::FN_ADDU, mse_pkg::FN_SUB,
			mse_pkg::FN_SUBU, mse_pkg::FN_AND, mse_pkg::FN_OR, mse_pkg::FN_NOR,
			mse_pkg::FN_SLT, mse_pkg::FN_SLTU, mse_pkg::FN_SLL, mse_pkg::FN_SRL,
			mse_pkg::FN_MULT, mse_pkg::FN_MULTU, mse_pkg::FN_DIV, mse_pkg::FN_DIVU,
			mse_pkg::FN_JR};
		logic [5:0]  ops [12] = '{mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU, mse_pkg::OP_ANDI,
			mse_pkg::OP_ORI, mse_pkg::OP_SLTI, mse_pkg::OP_SLTIU, mse_pkg::OP_BEQ,
			mse_pkg::OP_BNE, mse_pkg::OP_LW, mse_pkg::OP_SW, mse_pkg::OP_J,
			mse_pkg::OP_JAL};
		rs = $urandom_range(0, 7) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7));
		rt = $urandom_range(0, 7) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7));
		rd = $urandom_range(0, 7) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7));
		imm = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 64) - 32);
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			logic [5:0] fn;
			fn = fns[$urandom_range(0, 15)];
			if ((fn == mse_pkg::FN_DIV || fn == mse_pkg::FN_DIVU || fn == mse_pkg::FN_JR)
					&& $urandom_range(0, 2) != 0)
				fn = mse_pkg::FN_ADDU;
			return rtype(rs, rt, rd, 5'($urandom), fn);
		end
		if (pick < 90) begin
			logic [5:0] op;
			op = ops[$urandom_range(0, 11)];
			if (op == mse_pkg::OP_J || op == mse_pkg::OP_JAL)
				return {op, 26'($urandom)};
			return itype(op, rs, rt, imm);
		end
		if (pick < 93)
			return 32'h0;
		return $urandom;
	endfunction

	task automatic add_row(input logic [31:0] w, input logic known = 1'b0,
			input retire_t res = '0);
		row_t row;
		row.word = w;
		row.known = known;
		row.res = res;
		table_rows.insert(table_rows.size(), row);
	endtask

	task automatic send_item(input logic [31:0] w, input logic known = 1'b0,
			input retire_t typed = '0);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		instr_word <= w;
		drv_known <= known;
		drv_typed <= typed;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			model_reset();
		end else begin
			if (in_valid && in_ready) begin
				check_t c;
				execute_instr(instr_word, c.want);
				c.known = drv_known;
				c.typed = drv_typed;
				pending_q.insert(pending_q.size(), c);
				sent++;
			end
			if (out_valid && out_ready) begin
				check_t got;
				if (pending_q.size() == 0) begin
					$display("tb_top: unexpected result %0d", retired);
					errors++;
				end else begin
					got = pending_q.pop_front();
					compare_result(got.want);
					if (got.known)
						compare_result(got.typed);
				end
				retired++;
			end
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb_top: timeout after %0d cycles", cycles);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		retire_t r0;
		logic [31:0] w;
		send_idle_pct = 0; recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		instr_word = 32'h0;
		drv_known = 1'b0;
		drv_typed = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		r0 = '0; r0.npc = 32'd4; r0.cls = mse_pkg::CLS_NOP; r0.nexec = 32'd1;
		add_row(32'h0, 1'b1, r0);
		r0 = '0; r0.npc = 32'd8; r0.rwr = 1'b1; r0.ridx = 5'd3;
		r0.rval = mse_pkg::ALL_ONES; r0.maddr = 32'h10; r0.cls = mse_pkg::CLS_I;
		r0.nexec = 32'd2;
		add_row(itype(mse_pkg::OP_LW, 5'd0, 5'd3, 16'h0010), 1'b1, r0);
		add_row(itype(mse_pkg::OP_ADDIU, 5'd0, 5'd4, 16'h8000));
		add_row(itype(mse_pkg::OP_ORI, 5'd0, 5'd5, 16'hFFFF));
		add_row(itype(mse_pkg::OP_ADDI, 5'd0, 5'd0, 16'h1234));
		add_row(rtype(5'd4, 5'd5, 5'd6, 5'd0, mse_pkg::FN_ADDU));
		add_row(rtype(5'd4, 5'd5, 5'd7, 5'd0, mse_pkg::FN_SUB));
		add_row(rtype(5'd4, 5'd5, 5'd8, 5'd0, mse_pkg::FN_AND));
		add_row(rtype(5'd4, 5'd5, 5'd9, 5'd0, mse_pkg::FN_NOR));
		add_row(rtype(5'd4, 5'd5, 5'd10, 5'd0, mse_pkg::FN_SLT));
		add_row(rtype(5'd4, 5'd5, 5'd11, 5'd0, mse_pkg::FN_SLTU));
		add_row(rtype(5'd0, 5'd4, 5'd12, 5'd31, mse_pkg::FN_SLL));
		add_row(rtype(5'd0, 5'd12, 5'd13, 5'd31, mse_pkg::FN_SRL));
		add_row(rtype(5'd12, 5'd5, 5'd2, 5'd0, mse_pkg::FN_DIV));
		add_row(rtype(5'd4, 5'd0, 5'd14, 5'd0, mse_pkg::FN_DIVU));
		add_row(rtype(5'd4, 5'd5, 5'd15, 5'd0, mse_pkg::FN_MULT));
		add_row(itype(mse_pkg::OP_SLTI, 5'd4, 5'd16, 16'h7FFF));
		add_row(itype(mse_pkg::OP_SLTIU, 5'd4, 5'd17, 16'hFFFF));
		add_row(itype(mse_pkg::OP_ANDI, 5'd5, 5'd18, 16'hFFFF));
		add_row(itype(mse_pkg::OP_SW, 5'd29, 5'd5, 16'hFFFC));
		add_row(itype(mse_pkg::OP_LW, 5'd29, 5'd19, 16'hFFFF));
		add_row(itype(mse_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000));
		add_row(itype(mse_pkg::OP_BNE, 5'd0, 5'd0, 16'h7FFF));
		add_row({mse_pkg::OP_JAL, 26'h3FFFFFF});
		add_row({mse_pkg::OP_J, 26'h0});
		add_row(rtype(5'd0, 5'd0, 5'd0, 5'd0, 6'h3F));
		add_row({mse_pkg::OP_COP0, 26'h1});
		add_row(32'hFC00_0000);
		add_row(rtype(5'd31, 5'd0, 5'd0, 5'd0, mse_pkg::FN_JR));

		foreach (table_rows[i])
			send_item(table_rows[i].word, table_rows[i].known, table_rows[i].res);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				3: begin send_idle_pct = 26; recv_stall_pct = 26; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int k = 0; k < N_RANDOM / 5; k++) begin
				if (k == 200) begin
					in_valid <= 1'b0;
					@(negedge clk);
					while (pending_q.size() != 0)
						@(negedge clk);
				end
				w = random_word();
				send_item(w);
			end
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (50) @(posedge clk);
		$display("tb_top: %0d instructions sent, %0d results checked, %0d taken branches",
			sent, retired, taken_total);
		$display("tb_top: covered all ops, div by zero, $0 writes, jumps and halts");
		if (errors == 0 && sent == retired)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/mse_pkg.sv
hw/rtl/mse_ram.sv
hw/rtl/mse_ctrl.sv
hw/rtl/mse_dp.sv
hw/rtl/mips_subset_instruction_executor_core.sv
tb/sv/tb_top.sv
